@@ rtl/wsd_pkg.sv @@
// Shared types and constants for the WebSocket frame deframer.
`default_nettype none
package wsd_pkg;

  typedef enum logic [4:0] {
    PH_HEAD = 5'b00001,
    PH_LEN  = 5'b00010,
    PH_EXT  = 5'b00100,
    PH_KEY  = 5'b01000,
    PH_DATA = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key;
    logic [3:0] opcode;
    logic       fin;
    logic       last;
  } item_t;

  localparam logic [6:0] LEN_MASK   = 7'h7F;
  localparam logic [6:0] LEN_CODE16 = 7'd126;
  localparam logic [6:0] LEN_CODE64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

endpackage
`default_nettype wire

@@ rtl/wsd_front.sv @@
// Header parser: tracks frame phase, length and key, emits payload items.
`default_nettype none
module wsd_front import wsd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] in_byte,
  output item_t           item,
  output logic            push
);

  phase_t      phase_r, phase_nxt;
  logic [4:0]  hdr_r, hdr_nxt;
  logic        mask_r, mask_nxt;
  logic [3:0]  left_r, left_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  kpos_r, kpos_nxt;
  logic [6:0]  code;
  logic [7:0]  key_sel;

  assign code = in_byte[6:0] & LEN_MASK;

  always_comb begin
    case (kpos_r)
      2'd0:    key_sel = key_r[31:24];
      2'd1:    key_sel = key_r[23:16];
      2'd2:    key_sel = key_r[15:8];
      default: key_sel = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    mask_nxt  = mask_r;
    left_nxt  = left_r;
    rem_nxt   = rem_r;
    key_nxt   = key_r;
    kpos_nxt  = kpos_r;
    push      = 1'b0;
    item.data   = in_byte;
    item.key    = mask_r ? key_sel : 8'h00;
    item.opcode = hdr_r[3:0];
    item.fin    = hdr_r[4];
    item.last   = (rem_r == 64'd1);
    if (accept) begin
      unique case (phase_r)
        PH_LEN: begin
          mask_nxt = in_byte[7];
          if (code == LEN_CODE16) begin
            rem_nxt   = '0;
            left_nxt  = EXT16_BYTES;
            phase_nxt = PH_EXT;
          end else if (code == LEN_CODE64) begin
            rem_nxt   = '0;
            left_nxt  = EXT64_BYTES;
            phase_nxt = PH_EXT;
          end else begin
            rem_nxt = 64'(code);
            if (in_byte[7]) begin
              left_nxt  = KEY_BYTES;
              phase_nxt = PH_KEY;
            end else if (code == 7'd0) begin
              phase_nxt = PH_HEAD;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_EXT: begin
          rem_nxt  = {rem_r[55:0], in_byte};
          left_nxt = left_r - 4'd1;
          if (left_r == 4'd1) begin
            if (mask_r) begin
              left_nxt  = KEY_BYTES;
              phase_nxt = PH_KEY;
            end else if (rem_nxt == 64'd0) begin
              phase_nxt = PH_HEAD;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_KEY: begin
          key_nxt  = {key_r[23:0], in_byte};
          left_nxt = left_r - 4'd1;
          if (left_r == 4'd1) begin
            phase_nxt = (rem_r == 64'd0) ? PH_HEAD : PH_DATA;
          end
        end
        PH_DATA: begin
          push     = 1'b1;
          kpos_nxt = kpos_r + 2'd1;
          rem_nxt  = rem_r - 64'd1;
          if (rem_r == 64'd1) begin
            phase_nxt = PH_HEAD;
          end
        end
        default: begin
          hdr_nxt   = {in_byte[7], in_byte[3:0]};
          mask_nxt  = 1'b0;
          left_nxt  = '0;
          rem_nxt   = '0;
          key_nxt   = '0;
          kpos_nxt  = '0;
          phase_nxt = PH_LEN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD;
      hdr_r   <= '0;
      mask_r  <= 1'b0;
      left_r  <= '0;
      rem_r   <= '0;
      key_r   <= '0;
      kpos_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      mask_r  <= mask_nxt;
      left_r  <= left_nxt;
      rem_r   <= rem_nxt;
      key_r   <= key_nxt;
      kpos_r  <= kpos_nxt;
    end
  end

  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> rem_r != 64'd0)
    else $error("payload phase with zero bytes left");

  a_last_to_head: assert property (@(posedge clk) disable iff (!rst_n)
    push && item.last |=> phase_r == PH_HEAD)
    else $error("frame did not close after last payload byte");

endmodule
`default_nettype wire

@@ rtl/wsd_queue.sv @@
// Short item queue between the header parser and the output stage.
`default_nettype none
module wsd_queue import wsd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      pop_item,
  output logic       not_empty,
  output logic       not_full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign not_empty = (cnt_r != '0);
  assign not_full  = (cnt_r != CW'(DEPTH));
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> not_full)
    else $error("item pushed into full queue");

endmodule
`default_nettype wire

@@ rtl/wsd_back.sv @@
// Output stage: unmasks queued payload bytes into the result register.
`default_nettype none
module wsd_back import wsd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire item_t      q_item,
  input  wire logic       q_valid,
  output logic            q_pop,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,
  output logic [4:0]      out_tuser,
  output logic            out_tlast
);

  logic       vld_r, vld_nxt;
  logic [7:0] data_r;
  logic [4:0] user_r;
  logic       last_r;

  assign q_pop   = q_valid && (!vld_r || out_tready);
  assign vld_nxt = q_pop || (vld_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= q_item.data ^ q_item.key;
      user_r <= {q_item.fin, q_item.opcode};
      last_r <= q_item.last;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule
`default_nettype wire

@@ rtl/websocket_frame_deframer.sv @@
// Top level of the WebSocket receive-side frame deframer.
//
//   port group | dir | tdata               | tuser                       | tlast
//   in_        | in  | [7:0] received byte | -                           | -
//   out_       | out | [7:0] payload byte  | [3:0] opcode, [4] fin bit   | last of frame
//
// One byte per cycle sustained: the parser takes one byte per cycle while
// the queue has room, and the output register drains one transfer per cycle while
// out_tready is high. Payload bytes pass the queue, then the output register.
// Header, length and key bytes produce no output transfer.
// Reset (rst_n low, synchronous) returns the parser to the first header byte
// and empties the queue and output register.
// An output stall fills the queue; in_tready drops only when it is full.
`default_nettype none
module websocket_frame_deframer import wsd_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] payload_byte
  output logic [4:0]      out_tuser,  // [3:0] frame_opcode, [4] final_flag
  output logic            out_tlast
);

  item_t f_item;
  item_t q_item;
  logic  f_push;
  logic  q_valid;
  logic  q_pop;
  logic  q_room;
  logic  accept;

  assign in_tready = q_room;
  assign accept    = in_tvalid && in_tready;

  wsd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_tdata),
    .item    (f_item),
    .push    (f_push)
  );

  wsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_item (f_item),
    .pop       (q_pop),
    .pop_item  (q_item),
    .not_empty (q_valid),
    .not_full  (q_room)
  );

  wsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_item     (q_item),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

@@ test/tb_websocket_frame_deframer.sv @@
// Testbench for the WebSocket frame deframer: directed and random frame streams checked against a predictor.
module tb_websocket_frame_deframer import wsd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 4000;

  typedef enum logic [1:0] {
    LEN_SHORT,
    LEN_EXT16,
    LEN_EXT64
  } len_kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] opcode;
    logic       fin;
    logic       last;
  } payload_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [4:0] out_tuser;
  logic       out_tlast;

  // predicted parser state
  phase_t      rx_phase = PH_HEAD;
  logic [4:0]  rx_header = '0;
  logic        rx_masked = 1'b0;
  logic [3:0]  rx_hdr_left = '0;
  logic [63:0] rx_remaining = '0;
  logic [31:0] rx_key = '0;
  logic [1:0]  rx_key_pos = '0;

  payload_t expected_payload[$];

  int send_idle_pct = 9;
  int recv_idle_pct = 53;
  int error_count = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int payload_checked = 0;
  int idle_cycles = 0;

  websocket_frame_deframer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void enter_body();
    if (rx_masked) begin
      rx_hdr_left = KEY_BYTES;
      rx_phase = PH_KEY;
    end else if (rx_remaining == 0) begin
      rx_phase = PH_HEAD;
    end else begin
      rx_phase = PH_DATA;
    end
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    payload_t res;
    case (rx_phase)
      PH_LEN: begin
        rx_masked = b[7];
        if ((b[6:0] & LEN_MASK) == LEN_CODE16) begin
          rx_remaining = '0;
          rx_hdr_left = EXT16_BYTES;
          rx_phase = PH_EXT;
        end else if ((b[6:0] & LEN_MASK) == LEN_CODE64) begin
          rx_remaining = '0;
          rx_hdr_left = EXT64_BYTES;
          rx_phase = PH_EXT;
        end else begin
          rx_remaining = {57'd0, b[6:0] & LEN_MASK};
          enter_body();
        end
      end
      PH_EXT: begin
        rx_remaining = {rx_remaining[55:0], b};
        rx_hdr_left = rx_hdr_left - 4'd1;
        if (rx_hdr_left == 0) enter_body();
      end
      PH_KEY: begin
        rx_key = {rx_key[23:0], b};
        rx_hdr_left = rx_hdr_left - 4'd1;
        if (rx_hdr_left == 0) rx_phase = (rx_remaining == 0) ? PH_HEAD : PH_DATA;
      end
      PH_DATA: begin
        res.data = rx_masked ? (b ^ rx_key[8*(3-rx_key_pos) +: 8]) : b;
        rx_key_pos = rx_key_pos + 2'd1;
        rx_remaining = rx_remaining - 64'd1;
        res.opcode = rx_header[3:0];
        res.fin = rx_header[4];
        res.last = (rx_remaining == 0);
        expected_payload.push_back(res);
        if (rx_remaining == 0) rx_phase = PH_HEAD;
      end
      default: begin
        rx_header = {b[7], b[3:0]};
        rx_masked = 1'b0;
        rx_hdr_left = '0;
        rx_remaining = '0;
        rx_key = '0;
        rx_key_pos = '0;
        rx_phase = PH_LEN;
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    deframe_byte(b);
  endtask

  task automatic send_header(input logic [7:0] first, input logic masked, input len_kind_t kind,
                             input logic [63:0] len, input logic [31:0] key);
    send_byte(first);
    case (kind)
      LEN_SHORT: send_byte({masked, len[6:0]});
      LEN_EXT16: begin
        send_byte({masked, LEN_CODE16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, LEN_CODE64});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    end
    frames_sent++;
  endtask

  task automatic send_frame(input logic [7:0] first, input logic masked, input len_kind_t kind,
                            input int len, input logic [31:0] key);
    send_header(first, masked, kind, 64'(len), key);
    repeat (len) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_payload.size() != 0) @(posedge clk);
  endtask

  task automatic test_basic_frames();
    send_frame(8'hF1, 1'b0, LEN_SHORT, 1, 32'h0);
    send_frame(8'h09, 1'b0, LEN_SHORT, 0, 32'h0);
    send_frame(8'h8A, 1'b1, LEN_SHORT, 0, 32'hDEADBEEF);
    send_frame(8'h02, 1'b1, LEN_SHORT, 5, 32'hFF00A55A);
    send_frame(8'h8F, 1'b1, LEN_SHORT, 2, 32'h0123FEDC);
  endtask

  task automatic test_extended_lengths();
    send_frame(8'h80, 1'b1, LEN_EXT16, 0, 32'hFFFFFFFF);
    send_frame(8'h71, 1'b0, LEN_EXT16, 3, 32'h0);
    send_frame(8'h08, 1'b0, LEN_EXT64, 0, 32'h0);
    send_frame(8'h82, 1'b1, LEN_EXT64, 2, 32'h80402010);
    wait_drained();
  endtask

  task automatic test_random_frames(input int send_pct, input int recv_pct, input int budget);
    int stop_at;
    int pick;
    int len;
    len_kind_t kind;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        kind = LEN_SHORT;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 12);
      end else if (pick < 8) begin
        kind = LEN_EXT16;
        len = $urandom_range(0, 300);
      end else begin
        kind = LEN_EXT64;
        len = $urandom_range(0, 40);
      end
      send_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), kind, len, $urandom);
    end
    wait_drained();
  endtask

  // length with the top bit set never completes; the stream ends inside the payload
  task automatic test_oversized_length();
    send_header(8'h82, 1'b1, LEN_EXT64, 64'h8000_0000_0000_0005, $urandom);
    repeat (6) send_byte(8'($urandom_range(0, 255)));
    wait_drained();
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_payload
    payload_t want;
    if (rst_n && out_tvalid && out_tready) begin
      payload_checked++;
      if (expected_payload.size() == 0) begin
        error_count++;
        $error("unexpected payload transfer: data %0h", out_tdata);
      end else begin
        want = expected_payload.pop_front();
        if (out_tdata !== want.data) begin
          error_count++;
          $error("payload_byte: expected %0h, got %0h", want.data, out_tdata);
        end
        if (out_tuser[3:0] !== want.opcode) begin
          error_count++;
          $error("frame_opcode: expected %0h, got %0h", want.opcode, out_tuser[3:0]);
        end
        if (out_tuser[4] !== want.fin) begin
          error_count++;
          $error("final_flag: expected %0b, got %0b", want.fin, out_tuser[4]);
        end
        if (out_tlast !== want.last) begin
          error_count++;
          $error("frame_end: expected %0b, got %0b", want.last, out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_websocket_frame_deframer failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_frames();
    test_extended_lengths();
    test_random_frames(9, 53, 360);
    test_random_frames(53, 9, 360);
    test_random_frames(0, 0, 360);
    test_oversized_length();
    repeat (10) @(posedge clk);
    if (expected_payload.size() != 0) begin
      error_count++;
      $error("%0d payload bytes never came out", expected_payload.size());
    end
    $display("Sent %0d stream bytes in %0d frames of all length forms, masked and unmasked,",
             bytes_sent, frames_sent);
    $display("under sender and receiver stalls; checked %0d payload transfers.", payload_checked);
    if (error_count == 0) begin
      $display("tb_websocket_frame_deframer passed");
    end else begin
      $display("tb_websocket_frame_deframer failed");
    end
    $finish;
  end

endmodule

@@ websocket_frame_deframer.f @@
rtl/wsd_pkg.sv
rtl/wsd_front.sv
rtl/wsd_queue.sv
rtl/wsd_back.sv
rtl/websocket_frame_deframer.sv
test/tb_websocket_frame_deframer.sv
